// ===== src/pfba_pkg.sv =====
package pfba_pkg;

    localparam int ACTION_W    = 2;
    localparam int STATUS_W    = 2;
    localparam int ADDR_W      = 32;
    localparam int PAGE_ADDR_W = 27;
    localparam int UFB_W       = 12;
    localparam int PAGE_SHIFT  = 12;

    localparam int SUM_W  = 64;
    localparam int SUM_IW = 6;

    localparam logic [ACTION_W-1:0] ACT_ALLOC  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REINIT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOPAGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;

    localparam logic [7:0]       FULL_BYTE = 8'hFF;
    localparam logic [UFB_W-1:0] UFB_RESET = 12'd128;

endpackage

// ===== src/pfba_zero_find.sv =====
module pfba_zero_find #(
    parameter int W = 64
) (
    input  logic [W-1:0]                      word,
    output logic                              found,
    output logic [(W > 1 ? $clog2(W) : 1)-1:0] index
);

    localparam int IW = (W > 1) ? $clog2(W) : 1;

    always_comb
    begin
        found = 1'b0;
        index = '0;
        for (int i = W - 1; i >= 0; i--)
        begin
            if (!word[i])
            begin
                found = 1'b1;
                index = IW'(i);
            end
        end
    end

endmodule

// ===== src/page_frame_bitmap_allocator.sv =====
// Page frame allocator over a used-page bitmap held in a byte memory, with a
// second memory holding one "byte full" bit per bitmap byte, 64 bytes per word.
// A transaction starts when start is high and busy is low; its single result
// appears for one cycle with done high and must be taken then, since the
// receiver cannot stall the block. Allocation scans summary words from the
// start byte's word, each word read in S_SRCH_RD and checked in S_SRCH_CHK,
// then does the byte read-modify-write in S_MAP_RD and S_MAP_WR; busy stays
// high until that write, and a search that finds nothing ends with ST_NOPAGE
// after the last word. A free does only the byte read-modify-write. The result
// shows in the same cycle that busy falls; a free out of range, an unused action or a
// start byte past the map answers in the cycle after acceptance without raising
// busy. After reset and on every reinit the block sweeps both memories, one
// byte a cycle, with busy high; register writes are taken at any time.
module page_frame_bitmap_allocator #(
    parameter int MAP_BYTES      = 4096,
    parameter int RESERVED_BYTES = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  logic                             start,
    output logic                             busy,
    input  logic [pfba_pkg::ACTION_W-1:0]    action,
    input  logic                             kernel_req,
    input  logic [pfba_pkg::ADDR_W-1:0]      free_addr,
    output logic                             done,
    output logic [pfba_pkg::PAGE_ADDR_W-1:0] page_addr,
    output logic [pfba_pkg::STATUS_W-1:0]    status
);

    import pfba_pkg::*;

    localparam int BI     = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int NWORDS = (MAP_BYTES + SUM_W - 1) / SUM_W;
    localparam int WI     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int WCW    = WI + 1;
    localparam int SWW    = BI + 1;

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_SRCH_RD  = 3'd2;
    localparam logic [2:0] S_SRCH_CHK = 3'd3;
    localparam logic [2:0] S_MAP_RD   = 3'd4;
    localparam logic [2:0] S_MAP_WR   = 3'd5;

    logic [7:0]       map_mem [MAP_BYTES];
    logic [SUM_W-1:0] sum_mem [NWORDS];

    logic [2:0]             state_reg, state_next;
    logic                   is_alloc_reg, is_alloc_next;
    logic [WCW-1:0]         word_reg, word_next;
    logic [SUM_W-1:0]       mask_reg, mask_next;
    logic [BI-1:0]          byte_reg, byte_next;
    logic [2:0]             bit_reg, bit_next;
    logic [SWW-1:0]         sweep_reg, sweep_next;
    logic                   reinit_reg, reinit_next;
    logic [UFB_W-1:0]       ufb_reg;
    logic                   done_reg, done_next;
    logic [PAGE_ADDR_W-1:0] page_addr_reg, page_addr_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [7:0]             map_rd_reg;
    logic [SUM_W-1:0]       sum_rd_reg;

    logic             map_we, map_re, sum_we, sum_re;
    logic [BI-1:0]    map_wa, map_ra;
    logic [7:0]       map_wd;
    logic [WI-1:0]    sum_wa, sum_ra;
    logic [SUM_W-1:0] sum_wd;

    logic             srch_found;
    logic [SUM_IW-1:0] srch_idx;
    logic             byte_found;
    logic [2:0]       byte_idx;

    logic [SUM_W-1:0]  srch_word;
    logic [BI+5:0]     byte_pad;
    logic [WI-1:0]     byte_word;
    logic [SUM_IW-1:0] byte_pos;
    logic [UFB_W-1:0]  start_byte;
    logic [BI+14:0]    page_full;
    logic [7:0]        new_byte;
    logic [SUM_W-1:0]  clear_word;
    logic              accept;

    assign accept    = start && !busy;
    assign srch_word = sum_rd_reg | mask_reg;
    assign byte_pad  = {6'b0, byte_reg};
    assign byte_word = byte_pad[WI+5:6];
    assign byte_pos  = byte_pad[5:0];
    assign start_byte = kernel_req ? '0 : ufb_reg;
    assign page_full = {byte_reg, byte_idx, {PAGE_SHIFT{1'b0}}};

    pfba_zero_find #(.W(SUM_W)) u_srch_find (
        .word  (srch_word),
        .found (srch_found),
        .index (srch_idx)
    );

    pfba_zero_find #(.W(8)) u_byte_find (
        .word  (map_rd_reg),
        .found (byte_found),
        .index (byte_idx)
    );

    always_comb
    begin
        for (int j = 0; j < SUM_W; j++)
        begin
            clear_word[j] = (32'(sweep_reg) * SUM_W + j < RESERVED_BYTES) ||
                            (32'(sweep_reg) * SUM_W + j >= MAP_BYTES);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        is_alloc_next  = is_alloc_reg;
        word_next      = word_reg;
        mask_next      = mask_reg;
        byte_next      = byte_reg;
        bit_next       = bit_reg;
        sweep_next     = sweep_reg;
        reinit_next    = reinit_reg;
        done_next      = 1'b0;
        page_addr_next = page_addr_reg;
        status_next    = status_reg;

        map_we = 1'b0;
        map_wa = byte_reg;
        map_wd = map_rd_reg;
        map_re = 1'b0;
        map_ra = byte_reg;
        sum_we = 1'b0;
        sum_wa = byte_word;
        sum_wd = sum_rd_reg;
        sum_re = 1'b0;
        sum_ra = word_reg[WI-1:0];
        new_byte = map_rd_reg;

        case (state_reg)
            S_CLEAR:
            begin
                map_we = 1'b1;
                map_wa = sweep_reg[BI-1:0];
                map_wd = (32'(sweep_reg) < RESERVED_BYTES) ? FULL_BYTE : 8'h00;
                if (32'(sweep_reg) < NWORDS)
                begin
                    sum_we = 1'b1;
                    sum_wa = WI'(sweep_reg);
                    sum_wd = clear_word;
                end
                sweep_next = sweep_reg + 1'b1;
                if (32'(sweep_reg) == MAP_BYTES - 1)
                begin
                    state_next = S_IDLE;
                    if (reinit_reg)
                    begin
                        done_next      = 1'b1;
                        page_addr_next = '0;
                        status_next    = ST_OK;
                    end
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    page_addr_next = '0;
                    status_next    = ST_OK;
                    case (action)
                        ACT_ALLOC:
                        begin
                            if (32'(start_byte) >= MAP_BYTES)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NOPAGE;
                            end
                            else
                            begin
                                is_alloc_next = 1'b1;
                                word_next  = WCW'(start_byte[UFB_W-1:SUM_IW]);
                                mask_next  = (SUM_W'(1) << start_byte[SUM_IW-1:0]) - SUM_W'(1);
                                state_next = S_SRCH_RD;
                            end
                        end
                        ACT_FREE:
                        begin
                            if (32'(free_addr[31:15]) >= MAP_BYTES)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                is_alloc_next = 1'b0;
                                byte_next  = BI'(free_addr[31:15]);
                                bit_next   = free_addr[14:12];
                                state_next = S_MAP_RD;
                            end
                        end
                        ACT_REINIT:
                        begin
                            sweep_next  = '0;
                            reinit_next = 1'b1;
                            state_next  = S_CLEAR;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SRCH_RD:
            begin
                sum_re     = 1'b1;
                state_next = S_SRCH_CHK;
            end
            S_SRCH_CHK:
            begin
                if (srch_found)
                begin
                    byte_next  = BI'({word_reg[WI-1:0], srch_idx});
                    state_next = S_MAP_RD;
                end
                else
                begin
                    mask_next = '0;
                    word_next = word_reg + 1'b1;
                    if (word_reg + 1'b1 == WCW'(NWORDS))
                    begin
                        done_next      = 1'b1;
                        page_addr_next = '0;
                        status_next    = ST_NOPAGE;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_SRCH_RD;
                    end
                end
            end
            S_MAP_RD:
            begin
                map_re     = 1'b1;
                sum_re     = 1'b1;
                sum_ra     = byte_word;
                state_next = S_MAP_WR;
            end
            S_MAP_WR:
            begin
                map_we = 1'b1;
                sum_we = 1'b1;
                if (is_alloc_reg)
                begin
                    new_byte = map_rd_reg | (8'd1 << byte_idx);
                    sum_wd   = sum_rd_reg | (SUM_W'(new_byte == FULL_BYTE) << byte_pos);
                    page_addr_next = PAGE_ADDR_W'(page_full);
                end
                else
                begin
                    new_byte = map_rd_reg & ~(8'd1 << bit_reg);
                    sum_wd   = sum_rd_reg & ~(SUM_W'(1) << byte_pos);
                    page_addr_next = '0;
                end
                map_wd      = new_byte;
                done_next   = 1'b1;
                status_next = byte_found || !is_alloc_reg ? ST_OK : ST_NOPAGE;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_wa] <= map_wd;
        end
        if (map_re)
        begin
            map_rd_reg <= map_mem[map_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[sum_wa] <= sum_wd;
        end
        if (sum_re)
        begin
            sum_rd_reg <= sum_mem[sum_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            sweep_reg  <= '0;
            reinit_reg <= 1'b0;
            done_reg   <= 1'b0;
            ufb_reg    <= UFB_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            sweep_reg  <= sweep_next;
            reinit_reg <= reinit_next;
            done_reg   <= done_next;
            if (psel && penable && pwrite && !paddr[2])
            begin
                ufb_reg <= pwdata[UFB_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        is_alloc_reg  <= is_alloc_next;
        word_reg      <= word_next;
        mask_reg      <= mask_next;
        byte_reg      <= byte_next;
        bit_reg       <= bit_next;
        page_addr_reg <= page_addr_next;
        status_reg    <= status_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign page_addr = page_addr_reg;
    assign status    = status_reg;
    assign pready    = 1'b1;
    assign prdata    = paddr[2] ? 32'd0 : 32'(ufb_reg);

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import pfba_pkg::*;

    localparam int MAP_BYTES      = 4096;
    localparam int RESERVED_BYTES = 256;

    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
    localparam logic [2:0]          REG_USER_FIRST_BYTE = 3'd0;

    localparam int  PHASE_ITEMS   = 50;
    localparam int  RANDOM_PHASES = 25;
    localparam int  QUIET_PHASES  = 3;
    localparam int  TAIL_CYCLES   = 300;
    localparam longint CYCLE_LIMIT = 1_500_000;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                kernel_req;
        logic [ADDR_W-1:0]   free_addr;
    } page_req_t;

    typedef struct packed {
        logic [PAGE_ADDR_W-1:0] page_addr;
        logic [STATUS_W-1:0]    status;
    } page_resp_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    logic                   start      = 1'b0;
    logic                   busy;
    logic [ACTION_W-1:0]    action     = '0;
    logic                   kernel_req = 1'b0;
    logic [ADDR_W-1:0]      free_addr  = '0;
    logic                   done;
    logic [PAGE_ADDR_W-1:0] page_addr;
    logic [STATUS_W-1:0]    status;

    // shadow of the allocator
    logic [7:0]       used_map [MAP_BYTES];
    logic [UFB_W-1:0] user_first_byte;
    logic [ADDR_W-1:0] live_pages [$];

    page_req_t  req_q [$];
    page_resp_t resp_q [$];
    page_req_t  cur_req;

    int     errors   = 0;
    bit     no_gaps  = 1'b0;
    int     gap_left = 0;
    longint cycles   = 0;

    page_frame_bitmap_allocator #(
        .MAP_BYTES      (MAP_BYTES),
        .RESERVED_BYTES (RESERVED_BYTES)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .kernel_req (kernel_req),
        .free_addr  (free_addr),
        .done       (done),
        .page_addr  (page_addr),
        .status     (status)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic restore_used_map;
        for (int n = 0; n < MAP_BYTES; n++)
            used_map[n] = (n < RESERVED_BYTES) ? FULL_BYTE : 8'h00;
        live_pages.delete();
    endtask

    task automatic predict_response(input page_req_t r, output page_resp_t p);
        int               n;
        int               b;
        int               map_idx;
        bit               found;
        logic [ADDR_W-PAGE_SHIFT-1:0] page;
        p.page_addr = '0;
        p.status    = ST_OK;
        case (r.action)
            ACT_ALLOC:
            begin
                n = r.kernel_req ? 0 : int'(user_first_byte);
                found = 1'b0;
                while (n < MAP_BYTES && !found)
                begin
                    if (used_map[n] != FULL_BYTE)
                        found = 1'b1;
                    else
                        n++;
                end
                if (found)
                begin
                    b = 0;
                    while (used_map[n][b])
                        b++;
                    used_map[n][b] = 1'b1;
                    p.page_addr = PAGE_ADDR_W'((n * 8 + b) << PAGE_SHIFT);
                    live_pages.push_back(ADDR_W'((n * 8 + b) << PAGE_SHIFT));
                end
                else
                    p.status = ST_NOPAGE;
            end
            ACT_FREE:
            begin
                page = r.free_addr[ADDR_W-1:PAGE_SHIFT];
                map_idx = int'(page >> 3);
                if (map_idx >= MAP_BYTES)
                    p.status = ST_RANGE;
                else
                    used_map[map_idx][page[2:0]] = 1'b0;
            end
            ACT_REINIT:
                restore_used_map();
            default:
                ;
        endcase
    endtask

    task automatic push_req(input logic [ACTION_W-1:0] act, input logic kern,
                            input logic [ADDR_W-1:0] addr);
        page_req_t r;
        r.action     = act;
        r.kernel_req = kern;
        r.free_addr  = addr;
        req_q.push_back(r);
    endtask

    task automatic wait_idle;
        @(negedge clk);
        while (req_q.size() != 0 || start || resp_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_user_first_byte(input logic [UFB_W-1:0] v);
        logic [31:0] junk;
        junk = $urandom;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_USER_FIRST_BYTE;
        pwdata  <= {junk[31:UFB_W], v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        user_first_byte = v;
    endtask

    task automatic queue_random_requests(input int count);
        int sel;
        logic [ADDR_W-1:0] a;
        for (int k = 0; k < count; k++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
                push_req(ACT_ALLOC, 1'($urandom_range(0, 1)), $urandom);
            else if (sel < 70 && live_pages.size() != 0)
            begin
                a = live_pages[$urandom_range(0, live_pages.size() - 1)];
                push_req(ACT_FREE, 1'($urandom_range(0, 1)), a | $urandom_range(0, 4095));
            end
            else if (sel < 80)
                push_req(ACT_FREE, 1'($urandom_range(0, 1)), $urandom & 32'h07FF_FFFF);
            else if (sel < 87)
                push_req(ACT_FREE, 1'($urandom_range(0, 1)), $urandom);
            else if (sel < 93)
                push_req(ACT_FREE, 1'($urandom_range(0, 1)),
                         $urandom_range(0, RESERVED_BYTES * 8 * 4096 - 1));
            else if (sel < 98)
                push_req(ACT_NONE, 1'($urandom_range(0, 1)), $urandom);
            else
                push_req(ACT_REINIT, 1'($urandom_range(0, 1)), $urandom);
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        page_resp_t p;
        bit         accepted;
        if (!rst_n)
        begin
            start    <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            accepted = start && !busy;
            if (accepted)
            begin
                predict_response(cur_req, p);
                resp_q.push_back(p);
                if (!no_gaps && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 17);
            end
            else if (!start && gap_left > 0)
                gap_left--;

            if ((accepted || !start) && gap_left == 0 && req_q.size() != 0)
            begin
                cur_req = req_q.pop_front();
                start      <= 1'b1;
                action     <= cur_req.action;
                kernel_req <= cur_req.kernel_req;
                free_addr  <= cur_req.free_addr;
            end
            else if (accepted)
                start <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        page_resp_t want;
        if (rst_n && done)
        begin
            if (resp_q.size() == 0)
            begin
                $display("%0t: unexpected transaction: page_addr=%h status=%0d",
                         $time, page_addr, status);
                errors++;
            end
            else
            begin
                want = resp_q.pop_front();
                if (page_addr !== want.page_addr)
                begin
                    $display("%0t: page_addr mismatch: expected %h actual %h",
                             $time, want.page_addr, page_addr);
                    errors++;
                end
                if (status !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want.status, status);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        restore_used_map();
        user_first_byte = UFB_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset pattern, reserved page reuse, range checks
        push_req(ACT_ALLOC, 1'b1, 32'h0000_0000);
        push_req(ACT_ALLOC, 1'b0, 32'hFFFF_FFFF);
        push_req(ACT_FREE,  1'b0, 32'h0000_0FFF);
        push_req(ACT_ALLOC, 1'b1, 32'h0000_0000);
        push_req(ACT_FREE,  1'b1, 32'h0080_1ABC);
        push_req(ACT_FREE,  1'b0, 32'h0080_1000);
        push_req(ACT_FREE,  1'b0, 32'h0800_0000);
        push_req(ACT_FREE,  1'b1, 32'hFFFF_FFFF);
        push_req(ACT_FREE,  1'b0, 32'h07FF_FFFF);
        push_req(ACT_NONE,  1'b1, 32'hFFFF_FFFF);
        push_req(ACT_REINIT, 1'b0, 32'h0000_0000);
        push_req(ACT_ALLOC, 1'b0, 32'h0000_0000);
        wait_idle();

        // top byte only: fill it, then no page left
        write_user_first_byte(12'd4095);
        repeat (9) push_req(ACT_ALLOC, 1'b0, 32'h0000_0000);
        push_req(ACT_ALLOC, 1'b1, 32'h0000_0000);
        push_req(ACT_FREE,  1'b0, 32'h07FF_F123);
        push_req(ACT_ALLOC, 1'b0, 32'h0000_0000);
        wait_idle();

        write_user_first_byte(12'd0);
        push_req(ACT_ALLOC, 1'b0, 32'h0000_0000);
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph % 3 == 0)
            begin
                case ($urandom_range(0, 4))
                    0: write_user_first_byte(12'd0);
                    1: write_user_first_byte(12'd4095);
                    2: write_user_first_byte(UFB_RESET);
                    3: write_user_first_byte(UFB_W'($urandom_range(4080, 4095)));
                    default: write_user_first_byte(UFB_W'($urandom_range(0, 4095)));
                endcase
            end
            if (ph >= RANDOM_PHASES - QUIET_PHASES)
                no_gaps = 1'b1;
            queue_random_requests(PHASE_ITEMS);
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && resp_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/pfba_pkg.sv
src/pfba_zero_find.sv
src/page_frame_bitmap_allocator.sv
tb/tb_top.sv
